### rtl/dedup_error_event_ring_core_defines.svh
// assertion macros for the dedup error event ring core
// no dependencies; included by the rtl files that carry assertions
`ifndef DEDUP_ERROR_EVENT_RING_CORE_DEFINES_SVH
`define DEDUP_ERROR_EVENT_RING_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DEER_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DEER_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DEER_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DEER_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/deer_pkg.sv
// shared types and constants of the dedup error event ring core
// no dependencies
package deer_pkg;

    localparam int DEER_RING_DEPTH = 32;

    localparam logic [31:0] DEER_MIN_PERSIST_RESET = 32'd5000000;
    localparam logic [15:0] DEER_BOOT_COUNT_RESET  = 16'd0;

    // configuration register indexes
    localparam int          DEER_CFG_AW          = 1;
    localparam logic [0:0]  REG_MIN_PERSIST_US   = 1'b0;
    localparam logic [0:0]  REG_BOOT_COUNT       = 1'b1;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } deer_func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_CODE = 2'd1,
        ST_NOT_FOUND = 2'd2
    } deer_status_t;

    typedef struct packed {
        logic [15:0] code;
        logic [31:0] arg;
        logic [31:0] uptime;
        logic [15:0] boot;
    } deer_entry_t;

    typedef struct packed {
        logic entry_we;   // code, arg and boot
        logic uptime_we;  // uptime only
        logic rd_en;
    } deer_mem_ctl_t;

endpackage

### rtl/deer_store.sv
// slot storage of the event ring: one write port, one registered read port
// depends on deer_pkg
module deer_store import deer_pkg::*; #(
    parameter int RING_DEPTH = DEER_RING_DEPTH,
    parameter int AW         = $clog2(RING_DEPTH)
) (
    input  logic          aclk,
    input  deer_mem_ctl_t ctl,
    input  logic [AW-1:0] waddr,
    input  deer_entry_t   wdata,
    input  logic [AW-1:0] raddr,
    output deer_entry_t   rdata
);

    logic [15:0] code_mem   [RING_DEPTH];
    logic [31:0] arg_mem    [RING_DEPTH];
    logic [31:0] uptime_mem [RING_DEPTH];
    logic [15:0] boot_mem   [RING_DEPTH];

    deer_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.entry_we) begin
            code_mem[waddr] <= wdata.code;
            arg_mem[waddr]  <= wdata.arg;
            boot_mem[waddr] <= wdata.boot;
        end
        if (ctl.uptime_we) begin
            uptime_mem[waddr] <= wdata.uptime;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rdata_reg.code   <= code_mem[raddr];
            rdata_reg.arg    <= arg_mem[raddr];
            rdata_reg.uptime <= uptime_mem[raddr];
            rdata_reg.boot   <= boot_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dedup_error_event_ring_core.sv
// top level of the dedup error event ring core
// depends on deer_pkg, deer_store and dedup_error_event_ring_core_defines.svh
`include "dedup_error_event_ring_core_defines.svh"

// Circular log of RING_DEPTH error entries (code, arg, uptime seconds, boot number).
// func 0 adds an event: code 0 is rejected, a repeat of the last (code, arg) only
// refreshes the newest slot's uptime and asks for a storage write once min_persist_us
// has passed since the last one, anything else takes the head slot and always asks
// for a write. func 1 reads the index-th valid entry, oldest first, func 2 empties the
// ring. Every result carries the valid count. One item is accepted per clock while the
// result is not stalled; each item first waits in the input register, where ring pointers
// and the rate limit are worked out and the slot memory is written or read, and then sits
// in the result register, which drives m_tvalid. The memory's registered read port loads
// at the same edge as the result register, so read data lines up with its result. A
// stalled result holds the input register, and s_tready drops only while both registers
// are full. Reset needs no clearing pass: the fill count marks which slots hold data, so
// reset and clear take effect at once.
module dedup_error_event_ring_core import deer_pkg::*; #(
    parameter int RING_DEPTH = DEER_RING_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [DEER_CFG_AW-1:0] cfg_addr,
    input  logic [31:0]            cfg_wdata,

    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [135:0]           s_tdata,   // code, arg, now_s, now_us, index
    input  logic [1:0]             s_tuser,   // func

    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // persist_request, deduped, entry_code, entry_arg, entry_uptime_s, entry_boot,
    // valid_count
    output logic [103:0]           m_tdata,
    output logic [1:0]             m_tuser    // status
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = AW + 2;

    // ---------------- input register ----------------
    logic        a_valid_reg;
    logic [1:0]  a_func_reg;
    logic [15:0] a_code_reg;
    logic [31:0] a_arg_reg;
    logic [31:0] a_now_s_reg;
    logic [47:0] a_now_us_reg;
    logic [7:0]  a_index_reg;

    // ---------------- result register ----------------
    logic         b_valid_reg;
    deer_status_t b_status_reg;
    logic         b_persist_reg;
    logic         b_dedup_reg;
    logic         b_read_ok_reg;
    logic [5:0]   b_count_reg;

    // ---------------- ring state and configuration ----------------
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] filled_reg, filled_next;
    logic [15:0]   last_code_reg, last_code_next;
    logic [31:0]   last_arg_reg, last_arg_next;
    logic          last_valid_reg, last_valid_next;
    logic [47:0]   last_persist_reg, last_persist_next;
    logic [31:0]   min_persist_reg;
    logic [15:0]   boot_count_reg;

    // item moves from the input register into the result register
    logic advance_a;
    assign advance_a = a_valid_reg && (!b_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || advance_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_func_reg   <= s_tuser;
            a_code_reg   <= s_tdata[15:0];
            a_arg_reg    <= s_tdata[47:16];
            a_now_s_reg  <= s_tdata[79:48];
            a_now_us_reg <= s_tdata[127:80];
            a_index_reg  <= s_tdata[135:128];
        end
    end

    // ---------------- per-item logic ----------------
    logic          repeat_hit;
    logic [47:0]   elapsed_us;
    logic          persist_due;
    logic [AW-1:0] newest_slot;
    logic [AW-1:0] head_inc;
    logic [CW-1:0] filled_inc;
    logic [SW-1:0] rd_sum;
    logic [SW-1:0] rd_wrap;
    logic [AW-1:0] rd_slot;
    logic          index_ok;
    logic          new_entry;

    deer_status_t  status_next;
    logic          persist_next;
    logic          dedup_next;
    logic          read_ok_next;
    logic [CW+5:0] count_ext;

    deer_mem_ctl_t mem_ctl;
    logic [AW-1:0] mem_waddr;
    deer_entry_t   mem_wdata;
    deer_entry_t   mem_rdata;

    assign repeat_hit  = last_valid_reg && (a_code_reg == last_code_reg)
                         && (a_arg_reg == last_arg_reg);
    // modulo 2^48 elapsed time for the persist rate limit
    assign elapsed_us  = a_now_us_reg - last_persist_reg;
    assign persist_due = elapsed_us >= {16'd0, min_persist_reg};

    assign newest_slot = (head_reg == '0) ? AW'(RING_DEPTH - 1) : head_reg - 1'b1;
    assign head_inc    = (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign filled_inc  = (filled_reg == CW'(RING_DEPTH)) ? filled_reg : filled_reg + 1'b1;

    // oldest-first slot: head - filled + index, kept below twice the depth
    assign index_ok = (CW + 8)'(a_index_reg) < (CW + 8)'(filled_reg);
    assign rd_sum   = SW'(head_reg) + SW'(RING_DEPTH) - SW'(filled_reg) + SW'(a_index_reg);
    assign rd_wrap  = (rd_sum >= SW'(RING_DEPTH)) ? rd_sum - SW'(RING_DEPTH) : rd_sum;
    assign rd_slot  = rd_wrap[AW-1:0];

    always_comb begin
        head_next         = head_reg;
        filled_next       = filled_reg;
        last_code_next    = last_code_reg;
        last_arg_next     = last_arg_reg;
        last_valid_next   = last_valid_reg;
        last_persist_next = last_persist_reg;
        status_next       = ST_OK;
        persist_next      = 1'b0;
        dedup_next        = 1'b0;
        read_ok_next      = 1'b0;
        new_entry         = 1'b0;
        mem_ctl           = '0;
        mem_waddr         = head_reg;

        unique case (a_func_reg)
            FUNC_ADD: begin
                if (a_code_reg == 16'd0) begin
                    status_next = ST_ZERO_CODE;
                end else if (repeat_hit) begin
                    // fold onto the newest slot
                    dedup_next        = 1'b1;
                    mem_ctl.uptime_we = advance_a;
                    mem_waddr         = newest_slot;
                    if (persist_due) begin
                        persist_next      = 1'b1;
                        last_persist_next = a_now_us_reg;
                    end
                end else begin
                    new_entry         = 1'b1;
                    mem_ctl.entry_we  = advance_a;
                    mem_ctl.uptime_we = advance_a;
                    head_next         = head_inc;
                    filled_next       = filled_inc;
                    last_code_next    = a_code_reg;
                    last_arg_next     = a_arg_reg;
                    last_valid_next   = 1'b1;
                    persist_next      = 1'b1;
                    last_persist_next = a_now_us_reg;
                end
            end
            FUNC_READ: begin
                if (index_ok) begin
                    read_ok_next  = 1'b1;
                    mem_ctl.rd_en = advance_a;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            FUNC_CLEAR: begin
                head_next         = '0;
                filled_next       = '0;
                last_code_next    = '0;
                last_arg_next     = '0;
                last_valid_next   = 1'b0;
                persist_next      = 1'b1;
                last_persist_next = a_now_us_reg;
            end
            default: begin
                // unused func code: no effect
            end
        endcase
    end

    assign mem_wdata.code   = a_code_reg;
    assign mem_wdata.arg    = a_arg_reg;
    assign mem_wdata.uptime = a_now_s_reg;
    assign mem_wdata.boot   = boot_count_reg;

    // valid count wraps to six bits for deep rings
    assign count_ext = {6'd0, filled_next};

    deer_store #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_store (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_slot),
        .rdata (mem_rdata)
    );

    // ---------------- state update ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg         <= '0;
            filled_reg       <= '0;
            last_code_reg    <= '0;
            last_arg_reg     <= '0;
            last_valid_reg   <= 1'b0;
            last_persist_reg <= '0;
        end else if (advance_a) begin
            head_reg         <= head_next;
            filled_reg       <= filled_next;
            last_code_reg    <= last_code_next;
            last_arg_reg     <= last_arg_next;
            last_valid_reg   <= last_valid_next;
            last_persist_reg <= last_persist_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_persist_reg <= DEER_MIN_PERSIST_RESET;
            boot_count_reg  <= DEER_BOOT_COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MIN_PERSIST_US: min_persist_reg <= cfg_wdata;
                REG_BOOT_COUNT:     boot_count_reg  <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (advance_a) begin
            b_valid_reg <= 1'b1;
        end else if (m_tready) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_a) begin
            b_status_reg  <= status_next;
            b_persist_reg <= persist_next;
            b_dedup_reg   <= dedup_next;
            b_read_ok_reg <= read_ok_next;
            b_count_reg   <= count_ext[5:0];
        end
    end

    // entry fields are zero unless the item was a successful read
    deer_entry_t entry_out;
    assign entry_out = b_read_ok_reg ? mem_rdata : '0;

    assign m_tvalid = b_valid_reg;
    assign m_tuser  = b_status_reg;
    assign m_tdata  = {b_count_reg, entry_out.boot, entry_out.uptime, entry_out.arg,
                       entry_out.code, b_dedup_reg, b_persist_reg};

    // ---------------- assertions ----------------
    `DEER_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, filled_reg <= CW'(RING_DEPTH), "fill count above ring depth")
    `DEER_ASSERT_IMP(a_head_bound, aclk, aresetn, 1'b1, head_reg <= AW'(RING_DEPTH - 1), "head slot out of range")
    `DEER_ASSERT_IMP(a_last_has_entry, aclk, aresetn, last_valid_reg, filled_reg != '0, "last event remembered with empty ring")
    `DEER_ASSERT_NXT(a_new_entry_persists, aclk, aresetn, advance_a && new_entry, b_persist_reg && (b_status_reg == ST_OK) && (filled_reg != '0), "new entry without persist request")
    `DEER_ASSERT_IMP(a_dedup_not_read, aclk, aresetn, m_tvalid && b_dedup_reg, (b_status_reg == ST_OK) && !b_read_ok_reg, "deduped result flagged as read or error")

endmodule
